/* hw/rtl/assert_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a rising edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/dbmc_pkg.sv */
// -----------------------------------------------------------------------------
// dbmc_pkg
// Types, constants and helper functions of the drawbar to MIDI CC unit.
// -----------------------------------------------------------------------------
package dbmc_pkg;

	localparam int NUM_DRAWBARS = 38;
	localparam int IDX_W        = 6;
	localparam int POS_W        = 4;

	localparam logic [7:0] CC_STATUS = 8'hB0;
	localparam logic [7:0] PC_STATUS = 8'hC0;
	localparam logic [6:0] CTRL_BASE = 7'd70;
	localparam logic [1:0] NB_CC     = 2'd3;
	localparam logic [1:0] NB_PC     = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_UPPER_A = 3'd0;
	localparam logic [2:0] CFG_UPPER_B = 3'd1;
	localparam logic [2:0] CFG_BASS    = 3'd2;
	localparam logic [2:0] CFG_LOWER_A = 3'd3;
	localparam logic [2:0] CFG_LOWER_B = 3'd4;

	// preset codes
	localparam logic [4:0] PRE_UPPER_A = 5'd0;
	localparam logic [4:0] PRE_UPPER_B = 5'd1;
	localparam logic [4:0] PRE_LOWER_A = 5'd2;
	localparam logic [4:0] PRE_LOWER_B = 5'd3;
	localparam logic [4:0] PRE_UP_PRG0 = 5'd4;
	localparam logic [4:0] PRE_UP_PRG5 = 5'd9;
	localparam logic [4:0] PRE_LO_PRG0 = 5'd10;
	localparam logic [4:0] PRE_LO_PRG5 = 5'd15;
	localparam logic [4:0] PRE_BASS    = 5'd16;

	localparam logic OP_SAMPLE = 1'b0;

	typedef enum logic [2:0] {
		G_UPPER_A,
		G_UPPER_B,
		G_BASS,
		G_LOWER_A,
		G_LOWER_B
	} group_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SAMP,
		ST_RS_RD,
		ST_RS_DAT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [3:0] upper_a;
		logic [3:0] upper_b;
		logic [3:0] bass;
		logic [3:0] lower_a;
		logic [3:0] lower_b;
	} chan_cfg_t;

	typedef struct packed {
		logic       lower_led_on;
		logic       upper_led_on;
		logic       last;
		logic [1:0] message_bytes;
		logic [6:0] data_second;
		logic [6:0] data_first;
		logic [7:0] status_byte;
	} result_t;

	// (sample + 64) >> 7, gives 0..8
	function automatic logic [POS_W-1:0] quantize(input logic [9:0] smp);
		logic [10:0] sum;
		sum = {1'b0, smp} + 11'd64;
		return sum[10:7];
	endfunction

	// CC value by position; anything above 8 reads as position 8
	function automatic logic [6:0] cc_value(input logic [POS_W-1:0] p);
		logic [6:0] v;
		case (p)
			4'd0:    v = 7'd127;
			4'd1:    v = 7'd110;
			4'd2:    v = 7'd92;
			4'd3:    v = 7'd79;
			4'd4:    v = 7'd63;
			4'd5:    v = 7'd47;
			4'd6:    v = 7'd31;
			4'd7:    v = 7'd15;
			default: v = 7'd0;
		endcase
		return v;
	endfunction

	function automatic group_t group_of(input logic [IDX_W-1:0] idx);
		group_t g;
		if (idx <= 6'd8)       g = G_UPPER_A;
		else if (idx <= 6'd17) g = G_UPPER_B;
		else if (idx <= 6'd19) g = G_BASS;
		else if (idx <= 6'd28) g = G_LOWER_A;
		else                   g = G_LOWER_B;
		return g;
	endfunction

	// controller number; bass uses 70 and 72
	function automatic logic [6:0] ctrl_of(input logic [IDX_W-1:0] idx);
		logic [6:0] c;
		if (idx <= 6'd8)        c = CTRL_BASE + 7'(idx);
		else if (idx <= 6'd17)  c = CTRL_BASE + 7'(idx) - 7'd9;
		else if (idx == 6'd18)  c = CTRL_BASE;
		else if (idx == 6'd19)  c = CTRL_BASE + 7'd2;
		else if (idx <= 6'd28)  c = CTRL_BASE + 7'(idx) - 7'd20;
		else                    c = CTRL_BASE + 7'(idx) - 7'd29;
		return c;
	endfunction

endpackage

/* hw/rtl/dbmc_ram.sv */
// -----------------------------------------------------------------------------
// dbmc_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module dbmc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 38
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/dbmc_ctrl.sv */
// -----------------------------------------------------------------------------
// dbmc_ctrl
// Sequencer: read-compare-write of the position store for samples, group
// resend walks and program changes; builds one pending message at a time.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbmc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [23:0]         s_tdata,
	input  logic                s_tuser,
	input  dbmc_pkg::chan_cfg_t chan,
	input  logic                slot_free,
	output logic                push,
	output dbmc_pkg::result_t   res
);
	import dbmc_pkg::*;

	// input fields
	logic [IDX_W-1:0] in_drawbar;
	logic [9:0]       in_sample;
	logic [4:0]       in_preset;
	assign in_drawbar = s_tdata[5:0];
	assign in_sample  = s_tdata[15:6];
	assign in_preset  = s_tdata[20:16];

	state_t state_q, state_d;

	logic [IDX_W-1:0] idx_q, idx_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [IDX_W-1:0] cur_q, cur_d;
	logic [IDX_W-1:0] last_q, last_d;
	result_t          res_q, res_d;

	logic ua_q, ub_q, la_q, lb_q, uled_q, lled_q;
	logic ua_d, ub_d, la_d, lb_d, uled_d, lled_d;

	logic [NUM_DRAWBARS-1:0] valid_q;
	logic                    rvalid_s1;

	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [POS_W-1:0] ram_rdata;
	logic [POS_W-1:0] stored;
	logic             accept;
	logic             idx_ok;

	assign accept = s_tvalid && s_tready;
	assign idx_ok = in_drawbar < IDX_W'(NUM_DRAWBARS);
	assign stored = rvalid_s1 ? ram_rdata : '0;

	// position store
	dbmc_ram #(
		.WIDTH(POS_W),
		.DEPTH(NUM_DRAWBARS)
	) u_pos_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(pos_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	function automatic logic [3:0] chan_of(input group_t g, input chan_cfg_t c);
		logic [3:0] ch;
		unique case (g)
			G_UPPER_A: ch = c.upper_a;
			G_UPPER_B: ch = c.upper_b;
			G_BASS:    ch = c.bass;
			G_LOWER_A: ch = c.lower_a;
			default:   ch = c.lower_b;
		endcase
		return ch;
	endfunction

	function automatic result_t make_cc(input logic [IDX_W-1:0] idx,
			input logic [POS_W-1:0] p, input chan_cfg_t c,
			input logic lst, input logic ul, input logic ll);
		result_t r;
		r.status_byte   = CC_STATUS | {4'd0, chan_of(group_of(idx), c)};
		r.data_first    = ctrl_of(idx);
		r.data_second   = cc_value(p);
		r.message_bytes = NB_CC;
		r.last          = lst;
		r.upper_led_on  = ul;
		r.lower_led_on  = ll;
		return r;
	endfunction

	function automatic result_t make_pc(input logic [6:0] prg,
			input logic ul, input logic ll);
		result_t r;
		r.status_byte   = PC_STATUS;
		r.data_first    = prg;
		r.data_second   = 7'd0;
		r.message_bytes = NB_PC;
		r.last          = 1'b1;
		r.upper_led_on  = ul;
		r.lower_led_on  = ll;
		return r;
	endfunction

	// group active flag of a drawbar
	logic samp_active;
	always_comb begin
		unique case (group_of(idx_q))
			G_UPPER_A: samp_active = ua_q;
			G_UPPER_B: samp_active = ub_q;
			G_BASS:    samp_active = 1'b1;
			G_LOWER_A: samp_active = la_q;
			default:   samp_active = lb_q;
		endcase
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ua_q      <= 1'b1;
			ub_q      <= 1'b0;
			la_q      <= 1'b1;
			lb_q      <= 1'b0;
			uled_q    <= 1'b1;
			lled_q    <= 1'b1;
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			ua_q    <= ua_d;
			ub_q    <= ub_d;
			la_q    <= la_d;
			lb_q    <= lb_d;
			uled_q  <= uled_d;
			lled_q  <= lled_d;
			if (ram_we) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (ram_re) begin
				rvalid_s1 <= (ram_raddr < IDX_W'(NUM_DRAWBARS)) ? valid_q[ram_raddr] : 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		pos_q  <= pos_d;
		cur_q  <= cur_d;
		last_q <= last_d;
		res_q  <= res_d;
	end

	// next state and outputs
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		cur_d     = cur_q;
		last_d    = last_q;
		res_d     = res_q;
		ua_d      = ua_q;
		ub_d      = ub_q;
		la_d      = la_q;
		lb_d      = lb_q;
		uled_d    = uled_q;
		lled_d    = lled_q;
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = in_drawbar;
		push      = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					if (s_tuser == OP_SAMPLE) begin
						if (idx_ok) begin
							idx_d   = in_drawbar;
							pos_d   = quantize(in_sample);
							ram_re  = 1'b1;
							state_d = ST_SAMP;
						end
					end else begin
						unique case (in_preset) inside
							PRE_UPPER_A: begin
								uled_d = 1'b1; ua_d = 1'b1; ub_d = 1'b0;
								cur_d = 6'd0; last_d = 6'd8; state_d = ST_RS_RD;
							end
							PRE_UPPER_B: begin
								uled_d = 1'b0; ua_d = 1'b0; ub_d = 1'b1;
								cur_d = 6'd9; last_d = 6'd17; state_d = ST_RS_RD;
							end
							PRE_LOWER_A: begin
								lled_d = 1'b1; la_d = 1'b1; lb_d = 1'b0;
								cur_d = 6'd20; last_d = 6'd28; state_d = ST_RS_RD;
							end
							PRE_LOWER_B: begin
								lled_d = 1'b0; la_d = 1'b0; lb_d = 1'b1;
								cur_d = 6'd29; last_d = 6'd37; state_d = ST_RS_RD;
							end
							[PRE_UP_PRG0:PRE_UP_PRG5]: begin
								ua_d = 1'b0; ub_d = 1'b0;
								res_d = make_pc(7'(in_preset) + 7'd3, uled_q, lled_q);
								state_d = ST_EMIT;
							end
							[PRE_LO_PRG0:PRE_LO_PRG5]: begin
								la_d = 1'b0; lb_d = 1'b0;
								res_d = make_pc(7'(in_preset) - 7'd9, uled_q, lled_q);
								state_d = ST_EMIT;
							end
							PRE_BASS: begin
								cur_d = 6'd18; last_d = 6'd19; state_d = ST_RS_RD;
							end
							default: ;
						endcase
					end
				end
			end
			// stored position is on the read port now
			ST_SAMP: begin
				state_d = ST_IDLE;
				if (pos_q != stored) begin
					ram_we = 1'b1;
					if (samp_active) begin
						res_d   = make_cc(idx_q, pos_q, chan, 1'b1, uled_q, lled_q);
						state_d = ST_EMIT;
					end
				end
			end
			ST_RS_RD: begin
				ram_re    = 1'b1;
				ram_raddr = cur_q;
				state_d   = ST_RS_DAT;
			end
			ST_RS_DAT: begin
				res_d   = make_cc(cur_q, stored, chan, cur_q == last_q, uled_q, lled_q);
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					push = 1'b1;
					if (res_q.last) begin
						state_d = ST_IDLE;
					end else begin
						cur_d   = cur_q + 6'd1;
						state_d = ST_RS_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res = res_q;

	// checks
	`ASSERT_CLK(a_wr_in_samp, clk, arst_n, ram_we |-> (state_q == ST_SAMP && pos_q <= 4'd8), "position write outside compare step or out of range")
	`ASSERT_CLK(a_walk_bound, clk, arst_n, (state_q == ST_RS_RD) |-> (cur_q <= last_q && last_q < 6'(NUM_DRAWBARS)), "resend walk past group end")
	`ASSERT_CLK(a_push_free, clk, arst_n, push |-> slot_free, "message pushed into a busy output slot")
	`ASSERT_CLK(a_samp_read, clk, arst_n, (state_q == ST_SAMP) |-> $past(ram_re), "compare step without a prior store read")

endmodule

/* hw/rtl/dbmc_out_reg.sv */
// -----------------------------------------------------------------------------
// dbmc_out_reg
// Output register of the master stream; holds one message until transfer.
// -----------------------------------------------------------------------------
module dbmc_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dbmc_pkg::result_t res,
	output logic              slot_free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,
	output logic              m_tlast
);
	import dbmc_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign slot_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= res;
		end
	end

	// pack fields, first field lowest
	assign m_tvalid = valid_q;
	assign m_tlast  = data_q.last;
	assign m_tdata  = {6'd0, data_q.lower_led_on, data_q.upper_led_on,
		data_q.message_bytes, data_q.data_second, data_q.data_first,
		data_q.status_byte};

endmodule

/* hw/rtl/drawbar_scan_to_midi_cc_unit.sv */
// -----------------------------------------------------------------------------
// drawbar_scan_to_midi_cc_unit
// Quantizes drawbar wiper samples into nine positions and emits MIDI control
// changes; presets switch registrations, resend groups or send program changes.
// -----------------------------------------------------------------------------
// One item is handled at a time. A sample item is accepted, then compared
// with the position store, which takes the new position if it changed; a
// changed drawbar of an active group then hands its control change to the
// output register. Each message of a group resend goes through a store read,
// a build and a hand-off. The single read port of the position store makes
// every message wait for its own read; a stalled output stream holds the
// sequencer in its hand-off step. No clearing pass follows reset: each store
// entry has a valid bit that reads as position 0 until first written.
module drawbar_scan_to_midi_cc_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // drawbar[5:0], sample[15:6], preset[20:16]
	input  logic        s_tuser,   // op
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// status_byte[7:0], data_first[14:8], data_second[21:15],
	// message_bytes[23:22], upper_led_on[24], lower_led_on[25]
	output logic [31:0] m_tdata,
	output logic        m_tlast,
	// configuration writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [3:0]  cfg_data
);
	import dbmc_pkg::*;

	chan_cfg_t chan_q;
	result_t   res;
	logic      push;
	logic      slot_free;

	// channel registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q.upper_a <= 4'd0;
			chan_q.upper_b <= 4'd1;
			chan_q.bass    <= 4'd2;
			chan_q.lower_a <= 4'd3;
			chan_q.lower_b <= 4'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UPPER_A: chan_q.upper_a <= cfg_data;
				CFG_UPPER_B: chan_q.upper_b <= cfg_data;
				CFG_BASS:    chan_q.bass    <= cfg_data;
				CFG_LOWER_A: chan_q.lower_a <= cfg_data;
				CFG_LOWER_B: chan_q.lower_b <= cfg_data;
				default: ;
			endcase
		end
	end

	dbmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.chan     (chan_q),
		.slot_free(slot_free),
		.push     (push),
		.res      (res)
	);

	dbmc_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res      (res),
		.slot_free(slot_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
